/* rtl/ufc_pkg.sv */
// Shared types and constants for the UART frame checker with receive FIFO.
// Used by the top level and the checker; no dependencies.
`default_nettype none

package ufc_pkg;

  localparam int CMD_W       = 3;
  localparam int SLOT_W      = 10;
  localparam int DATA_W      = 8;
  localparam int BCNT_W      = 8;
  localparam int FRAME_CNT_W = 32;

  // Bit slot positions inside one sampled 8N1 frame.
  localparam int START_SLOT = 0;
  localparam int STOP_SLOT  = 9;

  // Largest value the byte count field can show.
  localparam logic [BCNT_W-1:0] BCNT_MAX = 8'hFF;

  // Command codes of an input transfer.
  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_FLUSH = 3'd3,
    CMD_START = 3'd4
  } cmd_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_POP_RD,
    ST_POP_OUT
  } ufc_state_t;

endpackage

`default_nettype wire

/* rtl/ufc_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds the ring FIFO and the staging buffer; no package dependency.
`default_nettype none

module ufc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/uart_frame_check_rx_fifo.sv */
// Top level: 8N1 frame checker, overwrite ring FIFO and staging buffer.
// Depends on ufc_pkg and ufc_ram.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_ready, cmd,         | into block
//           | sample_bits                      |
//   output  | out_valid, out_ready, read_data, | out of block
//           | read_valid, byte_count,          |
//           | frame_good, good_frames,         |
//           | bad_frames                       |
//
// Frame, peek, flush, start and unused codes, and a read with nothing buffered,
// finish at the accepting edge: the result is in the output register the next
// cycle. Other reads pass through ST_POP_RD and ST_POP_OUT, after ST_COPY when
// they refill the staging buffer, copying one ring RAM entry per cycle.
// One item is handled at a time; a new transfer is taken once the sequencer is
// idle and the output register is empty or being emptied. Reset is synchronous
// and needs no clearing pass.
`default_nettype none

module uart_frame_check_rx_fifo #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ufc_pkg::CMD_W-1:0]        cmd,
  input  logic [ufc_pkg::SLOT_W-1:0]       sample_bits,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ufc_pkg::DATA_W-1:0]       read_data,
  output logic                             read_valid,
  output logic [ufc_pkg::BCNT_W-1:0]       byte_count,
  output logic                             frame_good,
  output logic [ufc_pkg::FRAME_CNT_W-1:0]  good_frames,
  output logic [ufc_pkg::FRAME_CNT_W-1:0]  bad_frames
);

  import ufc_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = (CW + 1 > BCNT_W + 1) ? CW + 1 : BCNT_W + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(FIFO_DEPTH);

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  ufc_state_t state, state_next;

  logic [FRAME_CNT_W-1:0] good_count, good_next;
  logic [FRAME_CNT_W-1:0] bad_count, bad_next;
  logic [AW-1:0]          wr_idx, rd_idx;
  logic [CW-1:0]          ring_cnt;
  logic [AW-1:0]          stg_idx;
  logic [CW-1:0]          stg_rem;
  logic [AW-1:0]          copy_rptr;
  logic [CW-1:0]          copy_issued, copy_written;
  logic                   copy_pend;

  logic                   in_fire, out_fire, slot_free;
  logic                   is_frame, frame_ok, copy_last;
  logic                   load_idle, load_pop;
  logic [DATA_W-1:0]      frame_byte;
  logic [SW-1:0]          peek_sum, flush_sum;
  logic [BCNT_W-1:0]      peek_count, flush_count;

  logic                   ring_we, ring_re, stg_we, stg_re;
  logic [DATA_W-1:0]      ring_q, stg_q;

  // Handshakes and frame decode.
  assign out_fire   = out_valid && out_ready;
  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = (state == ST_IDLE) && slot_free;
  assign in_fire    = in_valid && in_ready;
  assign frame_ok   = !sample_bits[START_SLOT] && sample_bits[STOP_SLOT];
  assign frame_byte = sample_bits[STOP_SLOT-1:START_SLOT+1];
  assign is_frame   = in_fire && (cmd == CMD_FRAME);

  // Frame counters after this transfer.
  assign good_next = good_count + FRAME_CNT_W'(is_frame && frame_ok);
  assign bad_next  = bad_count + FRAME_CNT_W'(is_frame && !frame_ok);

  // Saturated byte counts for peek and flush.
  assign peek_sum    = SW'(ring_cnt) + SW'(stg_rem);
  assign flush_sum   = SW'(ring_cnt);
  assign peek_count  = (peek_sum > SW'(BCNT_MAX)) ? BCNT_MAX : peek_sum[BCNT_W-1:0];
  assign flush_count = (flush_sum > SW'(BCNT_MAX)) ? BCNT_MAX : flush_sum[BCNT_W-1:0];

  // The copy ends when the last ring entry lands in the staging buffer.
  assign copy_last = copy_pend && ((copy_written + 1'b1) == ring_cnt);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (cmd == CMD_READ)) begin
          if (stg_rem == '0 && ring_cnt != '0) begin
            state_next = ST_COPY;
          end else if (stg_rem != '0) begin
            state_next = ST_POP_RD;
          end
        end
      end
      ST_COPY: begin
        if (copy_last) begin
          state_next = ST_POP_RD;
        end
      end
      ST_POP_RD:  state_next = ST_POP_OUT;
      ST_POP_OUT: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Memory strobes and result loads.
  always_comb begin
    ring_we   = 1'b0;
    ring_re   = 1'b0;
    stg_we    = 1'b0;
    stg_re    = 1'b0;
    load_idle = 1'b0;
    load_pop  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ring_we   = is_frame && frame_ok;
        load_idle = in_fire &&
                    !((cmd == CMD_READ) && (stg_rem != '0 || ring_cnt != '0));
      end
      ST_COPY: begin
        ring_re = (copy_issued != ring_cnt);
        stg_we  = copy_pend;
      end
      ST_POP_RD:  stg_re = 1'b1;
      ST_POP_OUT: load_pop = 1'b1;
      default: ;
    endcase
  end

  // Ring FIFO storage.
  ufc_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(DATA_W), .AW(AW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (wr_idx),
    .wdata (frame_byte),
    .re    (ring_re),
    .raddr (copy_rptr),
    .rdata (ring_q)
  );

  // Staging buffer, filled from the ring and drained by reads.
  ufc_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(DATA_W), .AW(AW)) u_stage (
    .clk   (clk),
    .we    (stg_we),
    .waddr (copy_written[AW-1:0]),
    .wdata (ring_q),
    .re    (stg_re),
    .raddr (stg_idx),
    .rdata (stg_q)
  );

  // Control and pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      good_count   <= '0;
      bad_count    <= '0;
      wr_idx       <= '0;
      rd_idx       <= '0;
      ring_cnt     <= '0;
      stg_idx      <= '0;
      stg_rem      <= '0;
      copy_rptr    <= '0;
      copy_issued  <= '0;
      copy_written <= '0;
      copy_pend    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      good_count <= good_next;
      bad_count  <= bad_next;
      copy_pend  <= ring_re;
      // A new result takes the register even as the old one leaves.
      if (load_idle || load_pop) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (cmd) inside
              CMD_FRAME: begin
                if (frame_ok) begin
                  wr_idx <= next_slot(wr_idx);
                  if (ring_cnt != DEPTH_C) begin
                    ring_cnt <= ring_cnt + 1'b1;
                  end else begin
                    rd_idx <= next_slot(wr_idx);
                  end
                end
              end
              CMD_READ: begin
                if (stg_rem == '0 && ring_cnt != '0) begin
                  copy_rptr    <= rd_idx;
                  copy_issued  <= '0;
                  copy_written <= '0;
                end
              end
              CMD_FLUSH, CMD_START: begin
                wr_idx   <= '0;
                rd_idx   <= '0;
                ring_cnt <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_COPY: begin
          if (ring_re) begin
            copy_rptr   <= next_slot(copy_rptr);
            copy_issued <= copy_issued + 1'b1;
          end
          if (stg_we) begin
            copy_written <= copy_written + 1'b1;
          end
          if (copy_last) begin
            stg_rem  <= ring_cnt;
            stg_idx  <= '0;
            wr_idx   <= '0;
            rd_idx   <= '0;
            ring_cnt <= '0;
          end
        end
        ST_POP_OUT: begin
          stg_idx <= stg_idx + 1'b1;
          stg_rem <= stg_rem - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load_pop) begin
      read_data   <= stg_q;
      read_valid  <= 1'b1;
      byte_count  <= '0;
      frame_good  <= 1'b0;
      good_frames <= good_count;
      bad_frames  <= bad_count;
    end else if (load_idle) begin
      read_data   <= '0;
      read_valid  <= 1'b0;
      frame_good  <= is_frame && frame_ok;
      good_frames <= good_next;
      bad_frames  <= bad_next;
      case (cmd)
        CMD_PEEK:  byte_count <= peek_count;
        CMD_FLUSH: byte_count <= flush_count;
        default:   byte_count <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/ufc_chk.sv */
// Port-level checker for uart_frame_check_rx_fifo, attached by bind.
// Depends on ufc_pkg.
`default_nettype none

module ufc_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [ufc_pkg::CMD_W-1:0]        cmd,
  input logic [ufc_pkg::SLOT_W-1:0]       sample_bits,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ufc_pkg::DATA_W-1:0]       read_data,
  input logic                             read_valid,
  input logic [ufc_pkg::BCNT_W-1:0]       byte_count,
  input logic                             frame_good,
  input logic [ufc_pkg::FRAME_CNT_W-1:0]  good_frames,
  input logic [ufc_pkg::FRAME_CNT_W-1:0]  bad_frames
);

  import ufc_pkg::*;

  // A result held back by the consumer keeps its read data and frame counts.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) &&
      $stable(good_frames) && $stable(bad_frames))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A frame with a high start bit gives a bad-frame result on the next cycle.
  a_bad_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_FRAME && sample_bits[START_SLOT]
      |=> out_valid && !frame_good && !read_valid)
    else $error("bad frame not reported at once");

  // A popped byte and a frame verdict never share a result; no byte means zero data.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_valid && frame_good) &&
      (read_valid || read_data == '0) && (!read_valid || byte_count == '0))
    else $error("result fields inconsistent");

endmodule

bind uart_frame_check_rx_fifo ufc_chk u_ufc_chk (.*);

`default_nettype wire

/* test/tb_uart_frame_check_rx_fifo.sv */
// Testbench for uart_frame_check_rx_fifo: directed and random command traffic.
// Each response is checked against an in-bench copy of the frame checker state.
// Depends on ufc_pkg and the uart_frame_check_rx_fifo RTL.
module tb_uart_frame_check_rx_fifo;
  import ufc_pkg::*;

  localparam int RING_DEPTH   = 64;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 1026;
  localparam int PRINT_LIMIT  = 40;

  // Command codes that the block does not define.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Traffic mixes of the random part.
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_BLEND = 2;

  typedef struct packed {
    logic [DATA_W-1:0]      data;
    logic                   data_ok;
    logic [BCNT_W-1:0]      count;
    logic                   good;
    logic [FRAME_CNT_W-1:0] good_n;
    logic [FRAME_CNT_W-1:0] bad_n;
  } rx_response_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       cmd = '0;
  logic [SLOT_W-1:0]      sample_bits = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DATA_W-1:0]      read_data;
  logic                   read_valid;
  logic [BCNT_W-1:0]      byte_count;
  logic                   frame_good;
  logic [FRAME_CNT_W-1:0] good_frames;
  logic [FRAME_CNT_W-1:0] bad_frames;

  // Bench copy of the receive state.
  logic [DATA_W-1:0]      ring_mem[RING_DEPTH];
  logic [DATA_W-1:0]      stage_mem[RING_DEPTH];
  int unsigned            wr_ptr;
  int unsigned            rd_ptr;
  int unsigned            ring_fill;
  int unsigned            stage_ptr;
  int unsigned            stage_left;
  logic [FRAME_CNT_W-1:0] good_total;
  logic [FRAME_CNT_W-1:0] bad_total;

  rx_response_t rx_response_q[$];
  int           error_count = 0;
  int           burst_left = 0;
  int           idle_cycles = 0;
  int           stall_mode = 0;
  int           stall_left = 0;

  uart_frame_check_rx_fifo #(
    .FIFO_DEPTH(RING_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .sample_bits(sample_bits),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .read_valid(read_valid),
    .byte_count(byte_count),
    .frame_good(frame_good),
    .good_frames(good_frames),
    .bad_frames(bad_frames)
  );

  always #1 clk = ~clk;

  // Builds a well-formed frame: low start, data LSB first, high stop.
  function automatic logic [SLOT_W-1:0] good_frame(logic [DATA_W-1:0] b);
    return {1'b1, b, 1'b0};
  endfunction

  function automatic logic [BCNT_W-1:0] clip_count(int unsigned v);
    return (v > BCNT_MAX) ? BCNT_MAX : v[BCNT_W-1:0];
  endfunction

  task automatic empty_ring();
    wr_ptr = 0;
    rd_ptr = 0;
    ring_fill = 0;
  endtask

  // Applies one command to the bench state and returns the expected response.
  task automatic compute_rx_response(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] bits,
                                     output rx_response_t r);
    int unsigned src;
    r = '0;
    case (c)
      CMD_FRAME: begin
        if (bits[START_SLOT] || !bits[STOP_SLOT]) begin
          bad_total++;
        end else begin
          good_total++;
          r.good = 1'b1;
          ring_mem[wr_ptr] = bits[8:1];
          wr_ptr = (wr_ptr + 1) % RING_DEPTH;
          // A full ring drops its oldest byte.
          if (ring_fill < RING_DEPTH) ring_fill++;
          else rd_ptr = wr_ptr;
        end
      end
      CMD_READ: begin
        // Refill the staging buffer from the ring only when it has run dry.
        if (stage_left == 0 && ring_fill != 0) begin
          src = rd_ptr;
          for (int i = 0; i < ring_fill; i++) begin
            stage_mem[i] = ring_mem[src];
            src = (src + 1) % RING_DEPTH;
          end
          stage_left = ring_fill;
          stage_ptr = 0;
          empty_ring();
        end
        if (stage_left != 0) begin
          r.data = stage_mem[stage_ptr];
          r.data_ok = 1'b1;
          stage_ptr++;
          stage_left--;
        end
      end
      CMD_PEEK: r.count = clip_count(ring_fill + stage_left);
      CMD_FLUSH: begin
        r.count = clip_count(ring_fill);
        empty_ring();
      end
      CMD_START: empty_ring();
      default: ;
    endcase
    r.good_n = good_total;
    r.bad_n = bad_total;
  endtask

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("mismatch: %s", msg);
  endtask

  // Sends one command in bursts with random gaps, then records its response.
  task automatic send_command(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] bits);
    int gap;
    rx_response_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    sample_bits <= bits;
    do @(posedge clk); while (!in_ready);
    compute_rx_response(c, bits, r);
    rx_response_q.push_back(r);
  endtask

  // Holds off new transfers until every response has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (rx_response_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    // Reads and peeks with nothing buffered.
    send_command(CMD_READ, 10'h3FF);
    send_command(CMD_PEEK, 10'h000);
    // Field extremes: bad by low stop, bad by high start, good with 00 and FF.
    send_command(CMD_FRAME, 10'h000);
    send_command(CMD_FRAME, 10'h3FF);
    send_command(CMD_FRAME, 10'h200);
    send_command(CMD_FRAME, 10'h3FE);
    send_command(CMD_FRAME, good_frame(8'hA5));
    send_command(CMD_FRAME, good_frame(8'h5A));
    send_command(CMD_FRAME, 10'h201);
    send_command(CMD_PEEK, 10'h3FF);
    // First read refills the staging buffer; a new frame goes to the ring.
    send_command(CMD_READ, 10'h000);
    send_command(CMD_FRAME, good_frame(8'h3C));
    send_command(CMD_PEEK, 10'h000);
    send_command(CMD_FLUSH, 10'h3FF);
    // Flush keeps the staging buffer.
    repeat (4) send_command(CMD_READ, 10'h155);
    send_command(CMD_FRAME, good_frame(8'h81));
    send_command(CMD_START, 10'h2AA);
    send_command(CMD_READ, 10'h000);
    send_command(CMD_SPARE_LO, 10'h3FF);
    send_command(CMD_SPARE_MID, 10'h200);
    send_command(CMD_SPARE_HI, 10'h000);
    wait_drain();
  endtask

  task automatic test_ring_overwrite();
    // Overfill so the ring wraps and drops its oldest bytes.
    for (int i = 0; i < RING_DEPTH + 3; i++) send_command(CMD_FRAME, good_frame(8'(i * 7 + 1)));
    send_command(CMD_PEEK, 10'h000);
    for (int i = 0; i < RING_DEPTH + 1; i++) send_command(CMD_READ, 10'h000);
    // Full ring flush reports the full ring depth as its count.
    for (int i = 0; i < RING_DEPTH + 1; i++) send_command(CMD_FRAME, good_frame(8'($urandom)));
    send_command(CMD_FLUSH, 10'h000);
    send_command(CMD_PEEK, 10'h000);
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int mix;
    int mix_left;
    int pick;
    logic [SLOT_W-1:0] bits;
    mix = MIX_BLEND;
    mix_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mix_left == 0) begin
        mix = $urandom_range(MIX_FILL, MIX_BLEND);
        mix_left = $urandom_range(20, 150);
      end
      mix_left--;
      pick = $urandom_range(0, 99);
      // Shift the thresholds so each mix favors filling or draining.
      if (mix == MIX_FILL) pick = (pick < 85) ? 0 : (pick < 93) ? 50 : (pick < 97) ? 70 : 90;
      else if (mix == MIX_DRAIN) pick = (pick < 25) ? 0 : (pick < 85) ? 50 : (pick < 93) ? 70 : 90;
      else pick = (pick < 55) ? 0 : (pick < 80) ? 50 : (pick < 90) ? 70 : 90;
      bits = SLOT_W'($urandom_range(0, 1023));
      case (pick)
        0: begin
          if ($urandom_range(0, 3) != 0) begin
            bits[START_SLOT] = 1'b0;
            bits[STOP_SLOT] = 1'b1;
          end else if (!bits[START_SLOT] && bits[STOP_SLOT]) begin
            // Break one framing bit.
            if ($urandom_range(0, 1) == 1) bits[START_SLOT] = 1'b1;
            else bits[STOP_SLOT] = 1'b0;
          end
          send_command(CMD_FRAME, bits);
        end
        50: send_command(CMD_READ, bits);
        70: send_command(CMD_PEEK, bits);
        default: begin
          case ($urandom_range(0, 2))
            0: send_command(CMD_FLUSH, bits);
            1: send_command(CMD_START, bits);
            default: send_command(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), bits);
          endcase
        end
      endcase
    end
    wait_drain();
  endtask

  // Receiver ready follows changing stall patterns, including always-ready stretches.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= (stall_left < 4);
    endcase
  end

  // Compares each output transfer with the oldest expected response.
  always @(posedge clk) begin
    rx_response_t want;
    if (!rst && out_valid && out_ready) begin
      if (rx_response_q.size() == 0) begin
        report_mismatch("output transfer with no response pending");
      end else begin
        want = rx_response_q.pop_front();
        if (read_data !== want.data)
          report_mismatch($sformatf("read_data %h, wanted %h", read_data, want.data));
        if (read_valid !== want.data_ok)
          report_mismatch($sformatf("read_valid %b, wanted %b", read_valid, want.data_ok));
        if (byte_count !== want.count)
          report_mismatch($sformatf("byte_count %0d, wanted %0d", byte_count, want.count));
        if (frame_good !== want.good)
          report_mismatch($sformatf("frame_good %b, wanted %b", frame_good, want.good));
        if (good_frames !== want.good_n)
          report_mismatch($sformatf("good_frames %0d, wanted %0d", good_frames, want.good_n));
        if (bad_frames !== want.bad_n)
          report_mismatch($sformatf("bad_frames %0d, wanted %0d", bad_frames, want.bad_n));
      end
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    good_total = '0;
    bad_total = '0;
    stage_ptr = 0;
    stage_left = 0;
    empty_ring();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_ring_overwrite();
    test_random_traffic();
    // Let any stray output transfer show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && rx_response_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
